// ===== hdl/msp_pkg.sv =====
// ----------------------------------------------------------------------------
// msp_pkg: shared types, constants and microcode for the motor speed PID
// Field widths, register indexes, control word layout and the control program.
// ----------------------------------------------------------------------------
package msp_pkg;

	// field widths
	localparam int unsigned KEY_W      = 8;
	localparam int unsigned PERIOD_W   = 16;
	localparam int unsigned DUTY_W     = 8;
	localparam int unsigned SP_W       = 10;
	localparam int unsigned SPEED_W    = 10;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 12;

	// divider geometry: two quotient bits per cycle
	localparam int unsigned DIV_W     = 18;
	localparam int unsigned DEN_W     = 16;
	localparam int unsigned DIV_STEPS = DIV_W / 2;
	localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

	// key commands
	localparam logic [KEY_W-1:0] KEY_UP   = 8'd119;
	localparam logic [KEY_W-1:0] KEY_DOWN = 8'd115;

	// arithmetic constants
	localparam logic [DIV_W-1:0] SPEED_NUM = 18'd1000;
	localparam logic [DEN_W-1:0] DUTY_DEN  = 16'd1000;
	localparam logic [9:0]       TOTAL_MAX = 10'd1000;
	localparam logic [SP_W-1:0]  SP_RESET  = 10'd500;
	localparam logic [31:0]      INT_HI    = 32'h7FFF_FFFF;
	localparam logic [31:0]      INT_LO    = 32'h8000_0000;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BAND     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SP_STEP  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_SP_MAX   = 3'd5;

	// configuration register file
	typedef struct packed {
		logic [7:0]  gain_p;
		logic [11:0] gain_d_scaled;
		logic [7:0]  gain_i;
		logic [9:0]  integral_band;
		logic [7:0]  setpoint_step;
		logic [9:0]  setpoint_max;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		gain_p:        8'd7,
		gain_d_scaled: 12'd400,
		gain_i:        8'd2,
		integral_band: 10'd20,
		setpoint_step: 8'd20,
		setpoint_max:  10'd1000
	};

	// datapath micro-operations
	typedef enum logic [4:0] {
		OP_NOP,
		OP_FETCH,
		OP_SP_UPD,
		OP_DIV_SPEED,
		OP_SPEED_LD,
		OP_ERR,
		OP_DERR_BAND,
		OP_MUL_I,
		OP_INT_ACC,
		OP_MUL_P,
		OP_ACC_LD,
		OP_MUL_D,
		OP_ACC_ADD,
		OP_CLAMP,
		OP_DIV_DUTY,
		OP_DUTY_LD,
		OP_EMIT
	} op_t;

	// jump conditions
	typedef enum logic [2:0] {
		COND_NONE,
		COND_NO_IN,
		COND_DIV_BUSY,
		COND_OUT_FULL,
		COND_ALWAYS
	} cond_t;

	localparam int unsigned PC_W = 5;

	typedef struct packed {
		op_t             op;
		cond_t           cond;
		logic [PC_W-1:0] target;
	} ucode_t;

	// status fed back from the datapath to the sequencer
	typedef struct packed {
		logic in_valid;
		logic div_busy;
		logic out_full;
	} status_t;

	// program step addresses
	localparam logic [PC_W-1:0] STEP_FETCH      = 5'd0;
	localparam logic [PC_W-1:0] STEP_SP_UPD     = 5'd1;
	localparam logic [PC_W-1:0] STEP_DIV_SPEED  = 5'd2;
	localparam logic [PC_W-1:0] STEP_WAIT_SPEED = 5'd3;
	localparam logic [PC_W-1:0] STEP_SPEED_LD   = 5'd4;
	localparam logic [PC_W-1:0] STEP_ERR        = 5'd5;
	localparam logic [PC_W-1:0] STEP_DERR_BAND  = 5'd6;
	localparam logic [PC_W-1:0] STEP_MUL_I      = 5'd7;
	localparam logic [PC_W-1:0] STEP_INT_ACC    = 5'd8;
	localparam logic [PC_W-1:0] STEP_MUL_P      = 5'd9;
	localparam logic [PC_W-1:0] STEP_ACC_LD     = 5'd10;
	localparam logic [PC_W-1:0] STEP_MUL_D      = 5'd11;
	localparam logic [PC_W-1:0] STEP_ACC_ADD    = 5'd12;
	localparam logic [PC_W-1:0] STEP_CLAMP      = 5'd13;
	localparam logic [PC_W-1:0] STEP_DIV_DUTY   = 5'd14;
	localparam logic [PC_W-1:0] STEP_WAIT_DUTY  = 5'd15;
	localparam logic [PC_W-1:0] STEP_DUTY_LD    = 5'd16;
	localparam logic [PC_W-1:0] STEP_EMIT       = 5'd17;
	localparam logic [PC_W-1:0] STEP_RETURN     = 5'd18;

	// control program: one word per step
	function automatic ucode_t msp_ucode(input logic [PC_W-1:0] step);
		ucode_t uc;
		uc = '{op: OP_NOP, cond: COND_ALWAYS, target: STEP_FETCH};
		case (step)
			STEP_FETCH:      uc = '{op: OP_FETCH,     cond: COND_NO_IN,    target: STEP_FETCH};
			STEP_SP_UPD:     uc = '{op: OP_SP_UPD,    cond: COND_NONE,     target: STEP_FETCH};
			STEP_DIV_SPEED:  uc = '{op: OP_DIV_SPEED, cond: COND_NONE,     target: STEP_FETCH};
			STEP_WAIT_SPEED: uc = '{op: OP_NOP,       cond: COND_DIV_BUSY, target: STEP_WAIT_SPEED};
			STEP_SPEED_LD:   uc = '{op: OP_SPEED_LD,  cond: COND_NONE,     target: STEP_FETCH};
			STEP_ERR:        uc = '{op: OP_ERR,       cond: COND_NONE,     target: STEP_FETCH};
			STEP_DERR_BAND:  uc = '{op: OP_DERR_BAND, cond: COND_NONE,     target: STEP_FETCH};
			STEP_MUL_I:      uc = '{op: OP_MUL_I,     cond: COND_NONE,     target: STEP_FETCH};
			STEP_INT_ACC:    uc = '{op: OP_INT_ACC,   cond: COND_NONE,     target: STEP_FETCH};
			STEP_MUL_P:      uc = '{op: OP_MUL_P,     cond: COND_NONE,     target: STEP_FETCH};
			STEP_ACC_LD:     uc = '{op: OP_ACC_LD,    cond: COND_NONE,     target: STEP_FETCH};
			STEP_MUL_D:      uc = '{op: OP_MUL_D,     cond: COND_NONE,     target: STEP_FETCH};
			STEP_ACC_ADD:    uc = '{op: OP_ACC_ADD,   cond: COND_NONE,     target: STEP_FETCH};
			STEP_CLAMP:      uc = '{op: OP_CLAMP,     cond: COND_NONE,     target: STEP_FETCH};
			STEP_DIV_DUTY:   uc = '{op: OP_DIV_DUTY,  cond: COND_NONE,     target: STEP_FETCH};
			STEP_WAIT_DUTY:  uc = '{op: OP_NOP,       cond: COND_DIV_BUSY, target: STEP_WAIT_DUTY};
			STEP_DUTY_LD:    uc = '{op: OP_DUTY_LD,   cond: COND_NONE,     target: STEP_FETCH};
			STEP_EMIT:       uc = '{op: OP_EMIT,      cond: COND_OUT_FULL, target: STEP_EMIT};
			STEP_RETURN:     uc = '{op: OP_NOP,       cond: COND_ALWAYS,   target: STEP_FETCH};
			default:         uc = '{op: OP_NOP,       cond: COND_ALWAYS,   target: STEP_FETCH};
		endcase
		return uc;
	endfunction

endpackage

// ===== hdl/msp_if.sv =====
// ----------------------------------------------------------------------------
// msp_if: stream channels of the motor speed PID
// Command channel (key and encoder period) and result channel (duty, setpoint,
// speed), each with valid/ready handshake.
// ----------------------------------------------------------------------------
interface msp_cmd_if;
	logic                          valid;
	logic                          ready;
	logic [msp_pkg::KEY_W-1:0]     key_code;
	logic [msp_pkg::PERIOD_W-1:0]  period_ms;

	modport source (output valid, output key_code, output period_ms, input ready);
	modport sink   (input valid, input key_code, input period_ms, output ready);
endinterface

interface msp_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [msp_pkg::DUTY_W-1:0]    pwm_duty;
	logic [msp_pkg::SP_W-1:0]      setpoint_now;
	logic [msp_pkg::SPEED_W-1:0]   measured_speed;

	modport source (output valid, output pwm_duty, output setpoint_now,
		output measured_speed, input ready);
	modport sink   (input valid, input pwm_duty, input setpoint_now,
		input measured_speed, output ready);
endinterface

// ===== hdl/motor_speed_pid_core.sv =====
// ----------------------------------------------------------------------------
// motor_speed_pid_core: PID speed controller for a PWM-driven DC motor
// Microcoded sequencer over a small datapath with a shared iterative divider.
// ----------------------------------------------------------------------------
// Usage:
//   cmd: one transaction per control tick with key_code ('w' raises, 's'
//        lowers the setpoint) and period_ms (encoder period, 0 = stopped).
//   rsp: one transaction per command with pwm_duty, setpoint_now and
//        measured_speed.
//   cfg: write cfg_data to register cfg_index while cfg_we is high; indexes
//        0..5 are gain_p, gain_d_scaled, gain_i, integral_band,
//        setpoint_step, setpoint_max; other indexes are ignored.
// Program: a control program of 19 steps with two passes of the divider
//   (1000/period, then total*255/1000). One command is in work at a time;
//   the next command is taken at the fetch step that follows the emit and
//   return steps, so a result waiting in the output register does not hold
//   up the next command.
// Reset: registers take their default values, setpoint 500, error history
//   and integral cleared. If rsp stalls, the program waits at its emit step
//   until the output register is free.
// ----------------------------------------------------------------------------
module motor_speed_pid_core (
	input  logic                            clk,
	input  logic                            arst_n,
	msp_cmd_if.sink                         cmd,
	msp_rsp_if.source                       rsp,
	input  logic                            cfg_we,
	input  logic [msp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [msp_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import msp_pkg::*;

	cfg_t    cfg_q;
	op_t     op;
	status_t st;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_GAIN_P:  cfg_q.gain_p        <= cfg_data[7:0];
				CFG_GAIN_D:  cfg_q.gain_d_scaled <= cfg_data[11:0];
				CFG_GAIN_I:  cfg_q.gain_i        <= cfg_data[7:0];
				CFG_BAND:    cfg_q.integral_band <= cfg_data[9:0];
				CFG_SP_STEP: cfg_q.setpoint_step <= cfg_data[7:0];
				CFG_SP_MAX:  cfg_q.setpoint_max  <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	// command is taken only at the fetch step
	assign cmd.ready = (op == OP_FETCH);

	msp_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.st     (st),
		.op     (op)
	);

	msp_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.op             (op),
		.cfg            (cfg_q),
		.in_valid       (cmd.valid),
		.key_code       (cmd.key_code),
		.period_ms      (cmd.period_ms),
		.out_ready      (rsp.ready),
		.st             (st),
		.out_valid      (rsp.valid),
		.pwm_duty       (rsp.pwm_duty),
		.setpoint_now   (rsp.setpoint_now),
		.measured_speed (rsp.measured_speed)
	);

endmodule

// ===== hdl/msp_div.sv =====
// ----------------------------------------------------------------------------
// msp_div: iterative unsigned divider
// Restoring division, two quotient bits per cycle; busy from the cycle after
// start until the quotient is ready.
// ----------------------------------------------------------------------------
module msp_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [msp_pkg::DIV_W-1:0]    dividend,
	input  logic [msp_pkg::DEN_W-1:0]    divisor,
	output logic                         busy,
	output logic [msp_pkg::DIV_W-1:0]    quotient
);
	import msp_pkg::*;

	logic                 busy_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DEN_W-1:0]     rem_q;
	logic [DIV_W-1:0]     quo_q;
	logic [DEN_W-1:0]     den_q;
	logic [DEN_W-1:0]     rem_next;
	logic [DIV_W-1:0]     quo_next;
	logic [DEN_W:0]       trial;

	// two restoring steps per cycle
	always_comb begin
		rem_next = rem_q;
		quo_next = quo_q;
		trial    = '0;
		for (int i = 0; i < 2; i++) begin
			trial    = {rem_next, quo_next[DIV_W-1]};
			quo_next = {quo_next[DIV_W-2:0], 1'b0};
			if (trial >= {1'b0, den_q}) begin
				trial       = trial - {1'b0, den_q};
				quo_next[0] = 1'b1;
			end
			rem_next = trial[DEN_W-1:0];
		end
	end

	// control: busy flag and step count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
				busy_q <= 1'b0;
			end
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// operands and partial results
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			den_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_next;
			quo_q <= quo_next;
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("divider restarted while busy");

	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> (busy_q && cnt_q == '0))
		else $error("divider did not start");

endmodule

// ===== hdl/msp_seq.sv =====
// ----------------------------------------------------------------------------
// msp_seq: microcode sequencer
// Step counter over the control program, with conditional jumps on datapath
// status; issues one micro-operation per cycle.
// ----------------------------------------------------------------------------
module msp_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  msp_pkg::status_t  st,
	output msp_pkg::op_t      op
);
	import msp_pkg::*;

	logic [PC_W-1:0] pc_q;
	ucode_t          uc;
	logic            take_jump;

	// control word lookup
	assign uc = msp_ucode(pc_q);
	assign op = uc.op;

	// jump condition
	always_comb begin
		case (uc.cond)
			COND_NONE:     take_jump = 1'b0;
			COND_NO_IN:    take_jump = !st.in_valid;
			COND_DIV_BUSY: take_jump = st.div_busy;
			COND_OUT_FULL: take_jump = st.out_full;
			COND_ALWAYS:   take_jump = 1'b1;
			default:       take_jump = 1'b1;
		endcase
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= STEP_FETCH;
		end else if (take_jump) begin
			pc_q <= uc.target;
		end else begin
			pc_q <= pc_q + 1'b1;
		end
	end

	a_fetch_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(uc.op == OP_FETCH && st.in_valid) |=> (pc_q == STEP_SP_UPD))
		else $error("accepted transaction did not start the program");

	a_wait_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(uc.cond == COND_DIV_BUSY && st.div_busy) |=> $stable(pc_q))
		else $error("sequencer left a divider wait early");

endmodule

// ===== hdl/msp_dp.sv =====
// ----------------------------------------------------------------------------
// msp_dp: PID datapath
// Setpoint, error, integral and total registers, one shared multiplier and the
// iterative divider, all steered by the sequencer's micro-operation.
// ----------------------------------------------------------------------------
module msp_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  msp_pkg::op_t                  op,
	input  msp_pkg::cfg_t                 cfg,
	input  logic                          in_valid,
	input  logic [msp_pkg::KEY_W-1:0]     key_code,
	input  logic [msp_pkg::PERIOD_W-1:0]  period_ms,
	input  logic                          out_ready,
	output msp_pkg::status_t              st,
	output logic                          out_valid,
	output logic [msp_pkg::DUTY_W-1:0]    pwm_duty,
	output logic [msp_pkg::SP_W-1:0]      setpoint_now,
	output logic [msp_pkg::SPEED_W-1:0]   measured_speed
);
	import msp_pkg::*;

	// state
	logic [SP_W-1:0]      sp_q;
	logic signed [10:0]   perr_q;
	logic signed [31:0]   integ_q;
	logic                 out_valid_q;

	// working registers
	logic [KEY_W-1:0]     key_q;
	logic [PERIOD_W-1:0]  period_q;
	logic [SPEED_W-1:0]   speed_q;
	logic signed [11:0]   err_q;
	logic signed [11:0]   derr_q;
	logic                 band_q;
	logic signed [24:0]   prod_q;
	logic signed [33:0]   acc_q;
	logic [9:0]           tot_q;
	logic [DUTY_W-1:0]    duty_q;
	logic [DUTY_W-1:0]    duty_out_q;
	logic [SP_W-1:0]      sp_out_q;
	logic [SPEED_W-1:0]   speed_out_q;

	// combinational
	logic [SP_W:0]        sp_up_sum;
	logic [SP_W-1:0]      sp_next;
	logic signed [11:0]   err_next;
	logic signed [11:0]   derr_next;
	logic [11:0]          err_mag;
	logic [11:0]          mul_a;
	logic signed [11:0]   mul_b;
	logic signed [24:0]   mul_res;
	logic signed [32:0]   int_sum;
	logic [31:0]          int_sat;
	logic [9:0]           tot_next;
	logic [DIV_W-1:0]     duty_num;
	logic                 div_start;
	logic                 div_busy;
	logic [DIV_W-1:0]     div_quo;
	logic                 fetch;
	logic                 emit;

	assign fetch = (op == OP_FETCH) && in_valid;
	assign emit  = (op == OP_EMIT) && !out_valid_q;

	// setpoint step with saturation
	assign sp_up_sum = {1'b0, sp_q} + {3'b000, cfg.setpoint_step};
	always_comb begin
		sp_next = sp_q;
		if (key_q == KEY_UP) begin
			if (sp_q < cfg.setpoint_max) begin
				sp_next = (sp_up_sum > {1'b0, cfg.setpoint_max}) ?
					cfg.setpoint_max : sp_up_sum[SP_W-1:0];
			end
		end else if (key_q == KEY_DOWN) begin
			if (sp_q != '0) begin
				sp_next = (sp_q > {2'b00, cfg.setpoint_step}) ?
					sp_q - {2'b00, cfg.setpoint_step} : '0;
			end
		end
	end

	// error, its change and the band test
	assign err_next  = $signed({2'b00, sp_q}) - $signed({2'b00, speed_q});
	assign derr_next = err_q - {perr_q[10], perr_q};
	assign err_mag   = err_q[11] ? 12'(-err_q) : err_q;

	// shared multiplier: gain times error or error change
	always_comb begin
		case (op)
			OP_MUL_I: mul_a = {4'b0000, cfg.gain_i};
			OP_MUL_P: mul_a = {4'b0000, cfg.gain_p};
			default:  mul_a = cfg.gain_d_scaled;
		endcase
	end
	assign mul_b   = (op == OP_MUL_D) ? derr_q : err_q;
	assign mul_res = $signed({1'b0, mul_a}) * mul_b;

	// integral accumulate with 32-bit saturation
	assign int_sum = {integ_q[31], integ_q} + {{8{prod_q[24]}}, prod_q};
	always_comb begin
		if (int_sum[32] != int_sum[31]) begin
			int_sat = int_sum[32] ? INT_LO : INT_HI;
		end else begin
			int_sat = int_sum[31:0];
		end
	end

	// clamp of the total to 0..1000
	always_comb begin
		if (acc_q[33]) begin
			tot_next = '0;
		end else if ((acc_q[32:10] != '0) || (acc_q[9:0] > TOTAL_MAX)) begin
			tot_next = TOTAL_MAX;
		end else begin
			tot_next = acc_q[9:0];
		end
	end

	// total times 255 for the duty division
	assign duty_num = {tot_q, 8'h00} - {8'h00, tot_q};

	// divider: speed first, duty later
	assign div_start = (op == OP_DIV_SPEED) || (op == OP_DIV_DUTY);

	msp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ((op == OP_DIV_DUTY) ? duty_num : SPEED_NUM),
		.divisor  ((op == OP_DIV_DUTY) ? DUTY_DEN : period_q),
		.busy     (div_busy),
		.quotient (div_quo)
	);

	// controller state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q        <= SP_RESET;
			perr_q      <= '0;
			integ_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (op)
				OP_SP_UPD:  sp_q    <= sp_next;
				OP_INT_ACC: integ_q <= band_q ? $signed(int_sat) : '0;
				OP_DUTY_LD: perr_q  <= err_q[10:0];
				default: ;
			endcase
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// working registers, one micro-operation per cycle
	always_ff @(posedge clk) begin
		if (fetch) begin
			key_q    <= key_code;
			period_q <= period_ms;
		end
		case (op)
			OP_SPEED_LD:  speed_q <= (period_q == '0) ? '0 : div_quo[SPEED_W-1:0];
			OP_ERR:       err_q   <= err_next;
			OP_DERR_BAND: begin
				derr_q <= derr_next;
				band_q <= err_mag < {2'b00, cfg.integral_band};
			end
			OP_MUL_I,
			OP_MUL_P,
			OP_MUL_D:     prod_q  <= mul_res;
			OP_ACC_LD:    acc_q   <= {{2{integ_q[31]}}, integ_q} + {{9{prod_q[24]}}, prod_q};
			OP_ACC_ADD:   acc_q   <= acc_q + {{9{prod_q[24]}}, prod_q};
			OP_CLAMP:     tot_q   <= tot_next;
			OP_DUTY_LD:   duty_q  <= div_quo[DUTY_W-1:0];
			default: ;
		endcase
		if (emit) begin
			duty_out_q  <= duty_q;
			sp_out_q    <= sp_q;
			speed_out_q <= speed_q;
		end
	end

	assign st.in_valid  = in_valid;
	assign st.div_busy  = div_busy;
	assign st.out_full  = out_valid_q;

	assign out_valid      = out_valid_q;
	assign pwm_duty       = duty_out_q;
	assign setpoint_now   = sp_out_q;
	assign measured_speed = speed_out_q;

	a_emit_only: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(op == OP_EMIT))
		else $error("result raised outside the emit step");

	a_band_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(op == OP_INT_ACC && !band_q) |=> (integ_q == '0))
		else $error("integral not cleared outside the band");

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for motor_speed_pid_core
// Drives control transactions (key, encoder period) with random idling on
// both channels, predicts each result with an internal model of the setpoint,
// speed and PID arithmetic, and compares every result field in order.
// ----------------------------------------------------------------------------
module tb;
	import msp_pkg::*;

	localparam int unsigned SETTLE_CYCLES  = 40;
	localparam int unsigned QUIET_LIMIT    = 4000;
	localparam int unsigned REPORT_LIMIT   = 30;
	localparam int unsigned HOLD_CYCLES    = 300;
	localparam int unsigned PHASE_ITEMS    = 130;
	localparam int unsigned RANDOM_PHASES  = 5;
	localparam int unsigned INT_FILL_ITEMS = 8500;

	localparam longint SPEED_DIVIDEND = 1000;
	localparam longint TOTAL_CAP      = 1000;
	localparam longint DUTY_SCALE     = 255;
	localparam longint INT_SAT_HI     = 2147483647;
	localparam longint INT_SAT_LO     = -INT_SAT_HI - 1;

	// indexes past the register file, writes there must be ignored
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;
	localparam logic [KEY_W-1:0]     KEY_IDLE    = 8'd0;

	typedef struct packed {
		logic [DUTY_W-1:0]  pwm_duty;
		logic [SP_W-1:0]    setpoint_now;
		logic [SPEED_W-1:0] measured_speed;
	} pid_result_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	msp_cmd_if cmd();
	msp_rsp_if rsp();

	motor_speed_pid_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// controller state as the block should hold it
	cfg_t            ctl_cfg;
	logic [SP_W-1:0] ctl_setpoint;
	longint          ctl_prev_err;
	longint          ctl_integral;
	pid_result_t     pending_results[$];

	int unsigned error_count;
	int unsigned quiet_cycles;
	int unsigned hold_cycles;
	bit          cmd_idling;
	bit          rsp_idling;

	// 8 ns clock
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// one control step: setpoint key, speed, pid total, duty
	function automatic pid_result_t control_step(input logic [KEY_W-1:0] key,
			input logic [PERIOD_W-1:0] period);
		pid_result_t res;
		longint sp, sp_max, step, pd, speed, err, derr, mag, acc, total;
		longint kp, kd, ki, band;
		sp     = ctl_setpoint;
		sp_max = ctl_cfg.setpoint_max;
		step   = ctl_cfg.setpoint_step;
		kp     = ctl_cfg.gain_p;
		kd     = ctl_cfg.gain_d_scaled;
		ki     = ctl_cfg.gain_i;
		band   = ctl_cfg.integral_band;
		pd     = period;
		if (key == KEY_UP) begin
			if (sp < sp_max) begin
				acc = sp + step;
				sp = (acc > sp_max) ? sp_max : acc;
			end
		end else if (key == KEY_DOWN) begin
			if (sp > 0)
				sp = (sp > step) ? sp - step : 0;
		end
		speed = (pd == 0) ? 0 : SPEED_DIVIDEND / pd;
		err   = sp - speed;
		derr  = err - ctl_prev_err;
		mag   = (err < 0) ? -err : err;
		// integral runs inside the band, cleared outside it
		if (mag < band) begin
			acc = ctl_integral + ki * err;
			if (acc > INT_SAT_HI)
				acc = INT_SAT_HI;
			if (acc < INT_SAT_LO)
				acc = INT_SAT_LO;
			ctl_integral = acc;
		end else begin
			ctl_integral = 0;
		end
		total = kp * err + kd * derr + ctl_integral;
		ctl_prev_err = err;
		if (total < 0)
			total = 0;
		if (total > TOTAL_CAP)
			total = TOTAL_CAP;
		ctl_setpoint = sp[SP_W-1:0];
		res.pwm_duty       = total * DUTY_SCALE / TOTAL_CAP;
		res.setpoint_now   = sp[SP_W-1:0];
		res.measured_speed = speed[SPEED_W-1:0];
		return res;
	endfunction

	function automatic logic [KEY_W-1:0] pick_key();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 35)
			return KEY_UP;
		if (r < 70)
			return KEY_DOWN;
		return $urandom_range(0, 255);
	endfunction

	// in part periods that keep the speed near the setpoint, so the integral runs
	function automatic logic [PERIOD_W-1:0] pick_period();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 35 && ctl_setpoint != 0)
			return SPEED_DIVIDEND / ctl_setpoint + $urandom_range(0, 1);
		if (r < 45)
			return '0;
		if (r < 75)
			return $urandom_range(1, 40);
		if (r < 90)
			return $urandom_range(41, 1000);
		return $urandom_range(0, 65535);
	endfunction

	task automatic note_mismatch(input string field, input int want, input int got);
		error_count++;
		if (error_count <= REPORT_LIMIT)
			$error("%s: expected %0d, got %0d", field, want, got);
	endtask

	// register write, called and returning at a falling edge
	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		case (idx)
			CFG_GAIN_P:  ctl_cfg.gain_p        = data[7:0];
			CFG_GAIN_D:  ctl_cfg.gain_d_scaled = data[11:0];
			CFG_GAIN_I:  ctl_cfg.gain_i        = data[7:0];
			CFG_BAND:    ctl_cfg.integral_band = data[9:0];
			CFG_SP_STEP: ctl_cfg.setpoint_step = data[7:0];
			CFG_SP_MAX:  ctl_cfg.setpoint_max  = data[9:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// one command transaction, called and returning at a falling edge
	task automatic send_control(input logic [KEY_W-1:0] key,
			input logic [PERIOD_W-1:0] period);
		int unsigned gap;
		int unsigned r;
		gap = 0;
		if (cmd_idling) begin
			r = $urandom_range(0, 99);
			if (r < 15)
				gap = $urandom_range(1, 3);
			else if (r < 18)
				gap = $urandom_range(10, 40);
		end
		if (gap != 0) begin
			cmd.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd.valid     <= 1'b1;
		cmd.key_code  <= key;
		cmd.period_ms <= period;
		@(posedge clk);
		while (!cmd.ready)
			@(posedge clk);
		pending_results.push_back(control_step(key, period));
		@(negedge clk);
	endtask

	// stop offering commands and wait for every pending result
	task automatic drain_results();
		cmd.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic randomize_config();
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] high;
		logic [CFG_DATA_W-1:0] value;
		for (int i = 0; i <= int'(CFG_SP_MAX); i++) begin
			idx = i;
			case (idx)
				CFG_GAIN_D: high = 12'd4095;
				CFG_BAND:   high = 12'd1023;
				CFG_SP_MAX: high = 12'd1000;
				default:    high = 12'd255;
			endcase
			case ($urandom_range(0, 5))
				0: value = '0;
				1: value = high;
				2: value = $urandom_range(0, 4095);
				default: value = $urandom_range(0, high);
			endcase
			write_register(idx, value);
		end
		write_register(($urandom_range(0, 1) != 0) ? CFG_SPARE_7 : CFG_SPARE_6,
			$urandom_range(0, 4095));
	endtask

	// reset values of the registers, band edge, speed extremes
	task automatic test_reset_values();
		cmd_idling = 1'b0;
		rsp_idling = 1'b0;
		send_control(KEY_IDLE, 16'd0);
		send_control(KEY_UP, 16'd2);
		send_control(KEY_DOWN, 16'd2);
		send_control(KEY_DOWN, 16'd1);
		send_control(8'hFF, 16'hFFFF);
		send_control(KEY_UP - 8'd1, 16'd1000);
		send_control(KEY_DOWN + 8'd1, 16'd3);
		drain_results();
	endtask

	// setpoint saturation at both ends, lowered limit, zero step, masked limit
	task automatic test_setpoint_limits();
		write_register(CFG_SP_STEP, 12'd255);
		send_control(KEY_UP, 16'd0);
		send_control(KEY_UP, 16'd0);
		drain_results();
		write_register(CFG_SP_MAX, 12'd300);
		send_control(KEY_UP, 16'd0);
		repeat (5)
			send_control(KEY_DOWN, 16'd0);
		drain_results();
		write_register(CFG_SP_STEP, 12'd0);
		send_control(KEY_UP, 16'd0);
		drain_results();
		write_register(CFG_SP_MAX, 12'hFFF);
		write_register(CFG_SP_STEP, 12'hFFF);
		repeat (6)
			send_control(KEY_UP, 16'd0);
		drain_results();
	endtask

	// gains at their extremes through masked writes, spare indexes, zero band
	task automatic test_gain_extremes();
		write_register(CFG_GAIN_P, 12'hEFF);
		write_register(CFG_GAIN_D, 12'hFFF);
		write_register(CFG_GAIN_I, 12'h3FF);
		write_register(CFG_BAND, 12'hFFF);
		write_register(CFG_SPARE_6, 12'h000);
		write_register(CFG_SPARE_7, 12'hFFF);
		send_control(KEY_IDLE, 16'd0);
		send_control(KEY_IDLE, 16'd1);
		send_control(KEY_IDLE, 16'd2);
		drain_results();
		write_register(CFG_GAIN_P, 12'd0);
		write_register(CFG_GAIN_D, 12'd0);
		write_register(CFG_GAIN_I, 12'd0);
		write_register(CFG_BAND, 12'd0);
		send_control(KEY_IDLE, 16'h8000);
		send_control(KEY_DOWN, 16'd1);
		drain_results();
	endtask

	// result channel held off long enough for the block to stall its input
	task automatic test_output_stall();
		cmd_idling = 1'b0;
		rsp_idling = 1'b0;
		write_register(CFG_GAIN_P, 12'd7);
		write_register(CFG_GAIN_D, 12'd400);
		write_register(CFG_GAIN_I, 12'd2);
		write_register(CFG_BAND, 12'd20);
		write_register(CFG_SP_STEP, 12'd20);
		write_register(CFG_SP_MAX, 12'd1000);
		@(posedge clk);
		hold_cycles = HOLD_CYCLES;
		@(negedge clk);
		repeat (12)
			send_control(pick_key(), pick_period());
		drain_results();
	endtask

	// random traffic over several register settings
	task automatic test_random_control();
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			randomize_config();
			cmd_idling = (phase != 2);
			rsp_idling = (phase != 2);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				send_control(pick_key(), pick_period());
				if (n == PHASE_ITEMS / 2)
					drain_results();
			end
			drain_results();
		end
	endtask

	// integral driven into both 32-bit limits, then back across zero error
	task automatic test_integral_saturation();
		cmd_idling = 1'b0;
		rsp_idling = 1'b0;
		write_register(CFG_GAIN_P, 12'd0);
		write_register(CFG_GAIN_D, 12'd0);
		write_register(CFG_GAIN_I, 12'd255);
		write_register(CFG_BAND, 12'd1023);
		write_register(CFG_SP_STEP, 12'd255);
		write_register(CFG_SP_MAX, 12'd1000);
		repeat (5)
			send_control(KEY_DOWN, 16'd0);
		repeat (4)
			send_control(KEY_UP, 16'd0);
		repeat (INT_FILL_ITEMS)
			send_control(KEY_IDLE, 16'd0);
		repeat (2)
			send_control(KEY_DOWN, 16'd1);
		drain_results();
		write_register(CFG_BAND, 12'd0);
		send_control(KEY_IDLE, 16'd0);
		drain_results();
		write_register(CFG_BAND, 12'd1023);
		repeat (3)
			send_control(KEY_DOWN, 16'd1);
		repeat (INT_FILL_ITEMS)
			send_control(KEY_IDLE, 16'd1);
		send_control(KEY_UP, 16'd0);
		drain_results();
	endtask

	// result receiver: long hold on request, else random short and long gaps
	initial begin : result_receiver
		int unsigned gap_left;
		gap_left  = 0;
		rsp.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles != 0) begin
				hold_cycles--;
				rsp.ready <= 1'b0;
			end else if (gap_left != 0) begin
				gap_left--;
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= 1'b1;
				if (rsp_idling && $urandom_range(0, 99) < 15) begin
					if ($urandom_range(0, 9) == 0)
						gap_left = $urandom_range(15, 60);
					else
						gap_left = $urandom_range(1, 3);
				end
			end
		end
	end

	// compare each result transaction with the oldest prediction
	always @(posedge clk) begin : result_check
		pid_result_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (pending_results.size() == 0) begin
				error_count++;
				if (error_count <= REPORT_LIMIT)
					$error("result transaction with no command pending");
			end else begin
				want = pending_results.pop_front();
				if (rsp.pwm_duty !== want.pwm_duty)
					note_mismatch("pwm_duty", want.pwm_duty, rsp.pwm_duty);
				if (rsp.setpoint_now !== want.setpoint_now)
					note_mismatch("setpoint_now", want.setpoint_now, rsp.setpoint_now);
				if (rsp.measured_speed !== want.measured_speed)
					note_mismatch("measured_speed", want.measured_speed,
						rsp.measured_speed);
			end
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if (!arst_n || (cmd.valid && cmd.ready) || (rsp.valid && rsp.ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("motor_speed_pid_core verification failed");
				$finish;
			end
		end
	end

	initial begin
		error_count   = 0;
		quiet_cycles  = 0;
		hold_cycles   = 0;
		cmd_idling    = 1'b0;
		rsp_idling    = 1'b0;
		arst_n        = 1'b0;
		cmd.valid     = 1'b0;
		cmd.key_code  = '0;
		cmd.period_ms = '0;
		cfg_we        = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		ctl_cfg       = CFG_RESET;
		ctl_setpoint  = SP_RESET;
		ctl_prev_err  = 0;
		ctl_integral  = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_reset_values();
		test_setpoint_limits();
		test_gain_extremes();
		test_output_stall();
		test_random_control();
		test_integral_saturation();
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("motor_speed_pid_core verification clean");
		else
			$display("motor_speed_pid_core verification failed");
		$finish;
	end

endmodule

// ===== motor_speed_pid_core.f =====
hdl/msp_pkg.sv
hdl/msp_if.sv
hdl/msp_div.sv
hdl/msp_seq.sv
hdl/msp_dp.sv
hdl/motor_speed_pid_core.sv
sim/tb.sv
